[rtl/core/hsl_to_rgb_converter_defines.svh]
// Assertion macros for the HSL to RGB converter.
// Included by the top level; depends on nothing else.
`ifndef HSL_TO_RGB_CONVERTER_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hsl_pkg.sv]
// Shared types and constants of the HSL to RGB converter.
// Used by the front, queue, back and top modules; depends on nothing.
package hsl_pkg;

    localparam int HUE_W       = 16;
    localparam int LEVEL_W     = 13;
    localparam int WEIGHT_W    = 13;
    localparam int CHAN_W      = 8;
    localparam int C24_W       = 26;
    localparam int VAL_W       = 40;
    localparam int SCALED_W    = 45;
    localparam int FRAC_SHIFT  = 34;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 1;

    localparam logic [LEVEL_W-1:0]  ONE_Q12     = 13'd4096;
    localparam logic [LEVEL_W-1:0]  SAT_RESET   = 13'd4096;
    localparam logic [LEVEL_W-1:0]  LIGHT_RESET = 13'd1638;
    localparam logic [WEIGHT_W-1:0] SECTOR_SPAN = 13'd7680;
    localparam logic [HUE_W-1:0]    PAIR_SPAN   = 16'd15360;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SATURATION = 1'b0,
        REG_LIGHTNESS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    typedef struct packed {
        sector_t               sector;
        logic [WEIGHT_W-1:0]   weight;
    } front_item_t;

endpackage

[rtl/core/hsl_front.sv]
// Front stage of the HSL to RGB converter: accepts hues and classifies them
// into a sector and an in-sector weight. Depends on hsl_pkg.
module hsl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hsl_pkg::IN_TDATA_W-1:0] s_tdata,  // hue_angle
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsl_pkg::front_item_t          out_item
);
    import hsl_pkg::*;

    localparam logic [HUE_W-1:0] PAIR_1 = HUE_W'(1 * PAIR_SPAN);
    localparam logic [HUE_W-1:0] PAIR_2 = HUE_W'(2 * PAIR_SPAN);
    localparam logic [HUE_W-1:0] PAIR_3 = HUE_W'(3 * PAIR_SPAN);
    localparam logic [HUE_W-1:0] PAIR_4 = HUE_W'(4 * PAIR_SPAN);

    logic [HUE_W-1:0]    hue;
    logic [2:0]          pair;
    logic [HUE_W-1:0]    pos;
    logic                half;
    logic [3:0]          sector_idx;
    front_item_t         item;
    logic                valid_reg;
    logic                valid_next;
    front_item_t         item_reg;

    assign hue = s_tdata[HUE_W-1:0];

    always_comb begin
        priority if (hue >= PAIR_4) begin
            pair = 3'd4;
            pos  = hue - PAIR_4;
        end else if (hue >= PAIR_3) begin
            pair = 3'd3;
            pos  = hue - PAIR_3;
        end else if (hue >= PAIR_2) begin
            pair = 3'd2;
            pos  = hue - PAIR_2;
        end else if (hue >= PAIR_1) begin
            pair = 3'd1;
            pos  = hue - PAIR_1;
        end else begin
            pair = 3'd0;
            pos  = hue;
        end
    end

    always_comb begin
        half       = pos >= HUE_W'(SECTOR_SPAN);
        sector_idx = {pair, half};
        item.weight = half ? WEIGHT_W'(PAIR_SPAN - pos) : pos[WEIGHT_W-1:0];
        if (sector_idx >= 4'd5) begin
            item.sector = SEC_MAGENTA_RED;
        end else begin
            item.sector = sector_t'(sector_idx[2:0]);
        end
    end

    assign s_tready   = !valid_reg || out_ready;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/core/hsl_queue.sv]
// Short queue between the front and back stages of the HSL to RGB converter.
// Depends on hsl_pkg for the item type.
module hsl_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hsl_pkg::front_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hsl_pkg::front_item_t out_item
);
    import hsl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    front_item_t         mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/hsl_back.sv]
// Back stage of the HSL to RGB converter: holds the configuration, derives
// chroma terms, and computes the three channels. Depends on hsl_pkg.
module hsl_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hsl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hsl_pkg::LEVEL_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  hsl_pkg::front_item_t            in_item,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hsl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hsl_pkg::*;

    logic [LEVEL_W-1:0]      sat_reg;
    logic [LEVEL_W-1:0]      light_reg;
    logic [LEVEL_W-1:0]      s_cl;
    logic [LEVEL_W-1:0]      l_cl;
    logic [LEVEL_W:0]        two_l;
    logic [LEVEL_W-1:0]      dev;
    logic [LEVEL_W-1:0]      one_minus;
    logic [C24_W-1:0]        c24_next;
    logic [C24_W-1:0]        c24_reg;
    logic [C24_W-1:0]        l_shift;
    logic [C24_W-1:0]        m_base;
    logic [C24_W-1:0]        c2_next;
    logic [C24_W-1:0]        c2_reg;
    logic [VAL_W-1:0]        mval_next;
    logic [VAL_W-1:0]        mval_reg;
    logic [VAL_W-1:0]        cval_next;
    logic [VAL_W-1:0]        cval_reg;
    logic                    s1_valid_reg;
    sector_t                 s1_sector_reg;
    logic [VAL_W-1:0]        s1_xprod_reg;
    logic                    s2_ready;
    logic [VAL_W-1:0]        xval;
    logic [VAL_W-1:0]        r_val;
    logic [VAL_W-1:0]        g_val;
    logic [VAL_W-1:0]        b_val;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    function automatic logic [CHAN_W-1:0] to_level(input logic [VAL_W-1:0] v);
        logic [SCALED_W-1:0]            scaled;
        logic [SCALED_W-FRAC_SHIFT-1:0] q;
        scaled = {v, 4'b0000} + SCALED_W'(v);
        q      = scaled[SCALED_W-1:FRAC_SHIFT];
        return (q > (SCALED_W - FRAC_SHIFT)'(255)) ? {CHAN_W{1'b1}} : q[CHAN_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg   <= SAT_RESET;
            light_reg <= LIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SATURATION: sat_reg   <= cfg_wdata;
                REG_LIGHTNESS:  light_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        s_cl      = (sat_reg > ONE_Q12) ? ONE_Q12 : sat_reg;
        l_cl      = (light_reg > ONE_Q12) ? ONE_Q12 : light_reg;
        two_l     = {l_cl, 1'b0};
        dev       = (two_l >= {1'b0, ONE_Q12}) ? LEVEL_W'(two_l - {1'b0, ONE_Q12})
                                               : LEVEL_W'({1'b0, ONE_Q12} - two_l);
        one_minus = ONE_Q12 - dev;
        c24_next  = C24_W'(one_minus) * C24_W'(s_cl);
    end

    always_comb begin
        l_shift   = {l_cl, {LEVEL_W{1'b0}}};
        m_base    = (l_shift >= c24_reg) ? l_shift - c24_reg : '0;
        c2_next   = {c24_reg[C24_W-2:0], 1'b0};
        mval_next = VAL_W'(m_base) * VAL_W'(SECTOR_SPAN);
        cval_next = (VAL_W'(m_base) + VAL_W'(c2_next)) * VAL_W'(SECTOR_SPAN);
    end

    always_ff @(posedge aclk) begin
        c24_reg  <= c24_next;
        c2_reg   <= c2_next;
        mval_reg <= mval_next;
        cval_reg <= cval_next;
    end

    assign s2_ready = !m_tvalid_reg || m_tready;
    assign in_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                m_tvalid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            s1_sector_reg <= in_item.sector;
            s1_xprod_reg  <= VAL_W'(c2_reg) * VAL_W'(in_item.weight);
        end
    end

    always_comb begin
        xval = mval_reg + s1_xprod_reg;
        unique case (s1_sector_reg)
            SEC_RED_YELLOW: begin
                r_val = cval_reg;
                g_val = xval;
                b_val = mval_reg;
            end
            SEC_YELLOW_GREEN: begin
                r_val = xval;
                g_val = cval_reg;
                b_val = mval_reg;
            end
            SEC_GREEN_CYAN: begin
                r_val = mval_reg;
                g_val = cval_reg;
                b_val = xval;
            end
            SEC_CYAN_BLUE: begin
                r_val = mval_reg;
                g_val = xval;
                b_val = cval_reg;
            end
            SEC_BLUE_MAGENTA: begin
                r_val = xval;
                g_val = mval_reg;
                b_val = cval_reg;
            end
            default: begin
                r_val = cval_reg;
                g_val = mval_reg;
                b_val = xval;
            end
        endcase
        red   = to_level(r_val);
        green = to_level(g_val);
        blue  = to_level(b_val);
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_ready) begin
            m_tdata_reg <= {red, green, blue, blue, green, red};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/hsl_to_rgb_converter.sv]
// HSL to RGB converter: one hue per clock in, one RGB item per clock out while m_tready
// is held high. The stages are the front register, the queue entry, the weight
// multiply stage and the output register.
// Throughput is one item per cycle unless m_tready stalls the output. Configuration
// writes reach the chroma registers c24_reg, then c2_reg, mval_reg and cval_reg.
// Reset is synchronous, active low: it clears all valid flags and the queue and
// restores saturation 1.0 and lightness 1638/4096.
`include "hsl_to_rgb_converter_defines.svh"

module hsl_to_rgb_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hsl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hsl_pkg::LEVEL_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hsl_pkg::IN_TDATA_W-1:0]  s_tdata,  // hue_angle
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_level, green_level, blue_level, packed_colour
    output logic [hsl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hsl_pkg::*;

    logic        f_valid;
    front_item_t f_item;
    logic        q_in_ready;
    logic        q_valid;
    front_item_t q_item;
    logic        b_ready;

    hsl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (f_valid),
        .out_ready (q_in_ready),
        .out_item  (f_item)
    );

    hsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (q_in_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (b_ready),
        .out_item  (q_item)
    );

    hsl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (q_valid),
        .in_ready  (b_ready),
        .in_item   (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `HSL_ASSERT_SAME(a_full_queue_has_data, aclk, aresetn, !q_in_ready, q_valid, "queue full but empty")
    `HSL_ASSERT_SAME(a_stall_means_front_busy, aclk, aresetn, !s_tready, f_valid, "input stalled with idle front")
    `HSL_ASSERT_NEXT(a_front_holds_on_stall, aclk, aresetn, f_valid && !q_in_ready, (f_valid && f_item == $past(f_item)), "front item lost on stall")
    `HSL_ASSERT_SAME(a_packed_matches, aclk, aresetn, m_tvalid, (m_tdata[47:24] == {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]}), "packed colour mismatch")

endmodule
